// ===== rtl/abnf_pkg.sv =====
// shared constants and types for the alpha bleed neighbor fill block
package abnf_pkg;

  localparam int MAX_WIDTH = 2048;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int COL_W     = 12;
  localparam int ROW_W     = 17;
  localparam int CNT_W     = 27;
  localparam int SUM_W     = 11;
  localparam int NCNT_W    = 4;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef logic [2:0][SUM_W-1:0] sums_t;
  typedef logic [2:0][7:0]       quo_t;

  typedef struct packed {
    logic              start;
    sums_t             sums;
    logic [NCNT_W-1:0] cnt;
  } div_req_t;

endpackage

// ===== rtl/alpha_bleed_neighbor_fill.sv =====
// top level: 3x3 alpha bleeding on an rgba raster stream with two line memories
// Pixels enter in raster order and leave one row plus one pixel later. A pixel
// with alpha zero takes, per color channel, the floor average of its opaque
// 8-neighbors inside the frame; alpha stays zero, and with no opaque neighbor
// the pixel passes unchanged. After the last pixel send width+1 flush
// transactions (tuser high) to drain the tail; frame_last comes on tlast.
// One transaction is worked on at a time: an item that produces no result
// only does the read-modify-write of the line memories, an opaque or isolated
// one also sums its window, and a filled pixel also passes the 11-step divider.
// A new item is taken while a finished result still waits on the output.
// The line memories need no clearing: every read before a write is masked.
module alpha_bleed_neighbor_fill import abnf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // red, green, blue, alpha
  input  logic        in_tuser,   // flush
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // red, green, blue, alpha
  output logic        out_tlast,  // frame_last
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_wdata
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WR   = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [11:0]       width_r;
  logic [15:0]       height_r;
  logic [COL_W-1:0]  w_eff;
  logic [15:0]       h_eff;

  // frame position and counters
  logic [ADDR_W-1:0] col_r;
  logic [ROW_W-1:0]  row_r;
  logic [CNT_W-1:0]  emit_cnt_r;

  // current transaction
  logic [ADDR_W-1:0] x_r;
  logic [ROW_W-1:0]  y_r;
  logic [31:0]       pix_r;
  logic [31:0]       up_q, mid_q;
  logic [31:0]       win_r [9];

  // line memories
  logic [31:0]       upper_mem  [MAX_WIDTH];
  logic [31:0]       middle_mem [MAX_WIDTH];

  // result
  logic [31:0]       res_r;
  logic              res_last_r;
  logic              out_valid_r;
  logic [31:0]       out_data_r;
  logic              out_last_r;

  logic              accept;
  logic [ADDR_W-1:0] acc_x;
  logic [ROW_W-1:0]  acc_y;
  div_req_t          dreq;
  logic              ddone;
  quo_t              dquo;

  assign w_eff = (width_r == '0) ? COL_W'(1) :
                 (width_r > COL_W'(MAX_WIDTH)) ? COL_W'(MAX_WIDTH) : width_r;
  assign h_eff = (height_r == '0) ? 16'd1 : height_r;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  // column left past a narrowed width wraps to the next row
  always_comb begin
    if ({1'b0, col_r} >= w_eff) begin
      acc_x = '0;
      acc_y = row_r + ROW_W'(1);
    end else begin
      acc_x = col_r;
      acc_y = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 12'd2048;
      height_r <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_WIDTH:  width_r  <= cfg_wdata[11:0];
        REG_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // memory read on accept, write back of the shifted column in the cycle after
  always_ff @(posedge clk) begin
    if (accept) begin
      up_q  <= upper_mem[acc_x];
      mid_q <= middle_mem[acc_x];
    end
    if (state_r == S_WR) begin
      upper_mem[x_r]  <= mid_q;
      middle_mem[x_r] <= pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r   <= acc_x;
      y_r   <= acc_y;
      pix_r <= in_tuser ? 32'd0 : in_tdata;
    end
  end

  // neighborhood terms
  logic [COL_W-1:0] ccol;
  logic [ROW_W-1:0] crow;
  logic [2:0]       okc, okr;
  sums_t            sums;
  logic [NCNT_W-1:0] ncnt;
  logic [27:0]      total;
  logic             frame_end;
  logic             emit;
  logic [COL_W-1:0] next_col;

  always_comb begin
    if (x_r != '0) begin
      ccol = COL_W'(x_r) - COL_W'(1);
      crow = y_r - ROW_W'(1);
    end else begin
      ccol = w_eff - COL_W'(1);
      crow = y_r - ROW_W'(2);
    end
    okc = {(ccol + COL_W'(1)) < w_eff, 1'b1, ccol != '0};
    okr = {({1'b0, crow} + 18'd1) < {2'b00, h_eff}, 1'b1, crow != '0};
    sums = '0;
    ncnt = '0;
    for (int i = 0; i < 9; i++) begin
      if (i != 4 && okc[i / 3] && okr[i % 3] && win_r[i][31:24] != 8'd0) begin
        sums[0] = sums[0] + SUM_W'(win_r[i][7:0]);
        sums[1] = sums[1] + SUM_W'(win_r[i][15:8]);
        sums[2] = sums[2] + SUM_W'(win_r[i][23:16]);
        ncnt    = ncnt + NCNT_W'(1);
      end
    end
  end

  assign total     = 28'(w_eff) * 28'(h_eff);
  assign frame_end = ({1'b0, emit_cnt_r} + 28'd1) >= total;
  assign emit      = (y_r >= ROW_W'(2)) || (y_r == ROW_W'(1) && x_r != '0);
  assign next_col  = COL_W'(x_r) + COL_W'(1);

  assign dreq.start = (state_r == S_SUM) && (win_r[4][31:24] == 8'd0) && (ncnt != '0);
  assign dreq.sums  = sums;
  assign dreq.cnt   = ncnt;

  abnf_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (dreq),
    .done (ddone),
    .quo  (dquo)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept) state_nxt = S_WR;
      S_WR:   state_nxt = emit ? S_SUM : S_IDLE;
      S_SUM:  state_nxt = dreq.start ? S_DIV : S_OUT;
      S_DIV:  if (ddone) state_nxt = S_OUT;
      S_OUT:  if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      col_r      <= '0;
      row_r      <= '0;
      emit_cnt_r <= '0;
      for (int i = 0; i < 9; i++) win_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_WR) begin
        for (int i = 0; i < 6; i++) win_r[i] <= win_r[i + 3];
        win_r[6] <= up_q;
        win_r[7] <= mid_q;
        win_r[8] <= pix_r;
        if (next_col >= w_eff) begin
          col_r <= '0;
          row_r <= y_r + ROW_W'(1);
        end else begin
          col_r <= next_col[ADDR_W-1:0];
          row_r <= y_r;
        end
      end
      if (state_r == S_SUM) begin
        // frame done: window and counters restart for the next frame
        if (frame_end) begin
          col_r      <= '0;
          row_r      <= '0;
          emit_cnt_r <= '0;
          for (int i = 0; i < 9; i++) win_r[i] <= '0;
        end else begin
          emit_cnt_r <= emit_cnt_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_SUM) begin
      res_r      <= win_r[4];
      res_last_r <= frame_end;
    end else if (state_r == S_DIV && ddone) begin
      res_r[7:0]   <= dquo[0];
      res_r[15:8]  <= dquo[1];
      res_r[23:16] <= dquo[2];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && (!out_valid_r || out_tready)) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && (!out_valid_r || out_tready)) begin
      out_data_r <= res_r;
      out_last_r <= res_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== rtl/abnf_div.sv =====
// three-lane restoring divider, one quotient bit per cycle
module abnf_div import abnf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output logic     done,
  output quo_t     quo
);

  logic                         busy_r;
  logic                         done_r;
  logic [3:0]                   step_r;
  logic [NCNT_W-1:0]            cnt_r;
  logic [2:0][SUM_W-1:0]        dvd_r;
  logic [2:0][NCNT_W-1:0]       rem_r;
  logic [2:0][SUM_W-1:0]        dvd_nxt;
  logic [2:0][NCNT_W-1:0]       rem_nxt;

  always_comb begin
    logic [NCNT_W:0] sh;
    for (int l = 0; l < 3; l++) begin
      sh = {rem_r[l], dvd_r[l][SUM_W-1]};
      if (sh >= {1'b0, cnt_r}) begin
        rem_nxt[l] = NCNT_W'(sh - {1'b0, cnt_r});
        dvd_nxt[l] = {dvd_r[l][SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt[l] = sh[NCNT_W-1:0];
        dvd_nxt[l] = {dvd_r[l][SUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 4'd1;
        if (step_r == 4'(SUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.sums;
      rem_r <= '0;
      cnt_r <= req.cnt;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  always_comb begin
    for (int l = 0; l < 3; l++) quo[l] = dvd_r[l][7:0];
  end

endmodule

// ===== verif/tb_alpha_bleed_neighbor_fill.sv =====
// self-checking testbench for the alpha bleed neighbor fill block
module tb_alpha_bleed_neighbor_fill;
  import abnf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // one result transaction: packed rgba plus end-of-frame flag
  typedef struct packed {
    logic [31:0] rgba;
    logic        last;
  } pixel_out_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = 1'b0;
  logic [15:0] cfg_wdata = '0;

  alpha_bleed_neighbor_fill i_dut (.*);

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor state: own copy of registers, line memories, window and counters
  // ---------------------------------------------------------------------------
  logic [11:0] width_reg;
  logic [15:0] height_reg;
  logic [31:0] upper_row_mem [MAX_WIDTH];
  logic [31:0] middle_row_mem [MAX_WIDTH];
  logic [31:0] win [9];
  logic [31:0] next_col;
  logic [16:0] next_row;
  logic [26:0] pixels_out;

  pixel_out_t filled_q [$];   // pixels the block still owes us
  int         errors = 0;
  bit         quiet = 1'b0;   // no random idling on either side
  int         hold_req = 0;   // receiver hold-off requests from the tests
  int         hold_ack = 0;
  int         hold_left = 0;
  int         stall_count = 0;

  function automatic int eff_w();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int eff_h();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  function automatic void restart_frame();
    for (int k = 0; k < 9; k++) win[k] = '0;
    next_col = 0;
    next_row = 0;
    pixels_out = 0;
  endfunction

  // advance the 3x3 window by one accepted transaction and queue any result
  function automatic void bleed_predict(logic flush, logic [31:0] data);
    int unsigned w, h, total, x, row, ccol, crow, cnt;
    int unsigned sr, sg, sb;
    logic [31:0] pix, ctr, p;
    logic [7:0]  r, g, b, a;
    bit          okc [3];
    bit          okr [3];
    pixel_out_t  res;
    w = eff_w();
    h = eff_h();
    total = w * h;
    if (next_col >= w) begin
      next_col = 0;
      next_row = 17'(next_row + 1);
    end
    x = next_col;
    row = next_row;
    pix = flush ? 32'h0 : data;
    // window column 2 gets two rows up, one row up and the new pixel
    for (int k = 0; k < 6; k++) win[k] = win[k+3];
    win[6] = upper_row_mem[x % MAX_WIDTH];
    win[7] = middle_row_mem[x % MAX_WIDTH];
    win[8] = pix;
    upper_row_mem[x % MAX_WIDTH] = middle_row_mem[x % MAX_WIDTH];
    middle_row_mem[x % MAX_WIDTH] = pix;
    if (x > 0) begin
      ccol = x - 1;
      crow = row - 1;
    end else begin
      ccol = w - 1;
      crow = row - 2;
    end
    next_col = x + 1;
    if (next_col >= w) begin
      next_col = 0;
      next_row = 17'(row + 1);
    end
    // nothing leaves until the window center holds a real pixel
    if (!((row >= 2) || (row == 1 && x >= 1))) return;
    ctr = win[4];
    {a, b, g, r} = ctr;
    if (a == 0) begin
      sr = 0; sg = 0; sb = 0; cnt = 0;
      okc[0] = ccol > 0; okc[1] = 1; okc[2] = ccol + 1 < w;
      okr[0] = crow > 0; okr[1] = 1; okr[2] = crow + 1 < h;
      for (int c = 0; c < 3; c++)
        for (int rr = 0; rr < 3; rr++) begin
          p = win[c*3 + rr];
          // skip the center, masked edge positions and transparent neighbors
          if (!(c == 1 && rr == 1) && okc[c] && okr[rr] && p[31:24] != 0) begin
            sr += p[7:0];
            sg += p[15:8];
            sb += p[23:16];
            cnt++;
          end
        end
      if (cnt != 0) begin
        r = 8'(sr / cnt);
        g = 8'(sg / cnt);
        b = 8'(sb / cnt);
      end
    end
    res.rgba = {a, b, g, r};
    if (pixels_out + 1 >= total) begin
      res.last = 1'b1;
      restart_frame();
    end else begin
      res.last = 1'b0;
      pixels_out = 27'(pixels_out + 1);
    end
    filled_q.push_back(res);
  endfunction

  // ---------------------------------------------------------------------------
  // sender: one transaction, optional random gap before it
  // ---------------------------------------------------------------------------
  task automatic send_pixel(logic flush, logic [31:0] data);
    if (!quiet && $urandom_range(99) < 25) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(3)) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= flush;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    bleed_predict(flush, data);
  endtask

  // register writes happen only with the block idle
  task automatic write_reg(logic idx, logic [15:0] val);
    @(negedge clk);
    in_tvalid <= 1'b0;
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_WIDTH) width_reg = val[11:0];
    else height_reg = val;
  endtask

  // wait for every owed pixel, then let the divider settle
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (filled_q.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_pixel(int clear_pct);
    logic [31:0] v;
    v = $urandom;
    if ($urandom_range(99) < clear_pct) v[31:24] = 8'h00;
    return v;
  endfunction

  // one complete frame: pixels, then width+1 tail transactions
  // tail transactions are mostly flushes, sometimes extra pixels past the frame
  task automatic run_frame(logic [15:0] w, logic [15:0] h, int clear_pct, int flush_pct);
    int n;
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    n = eff_w() * eff_h();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < flush_pct) send_pixel(1'b1, $urandom);
      else send_pixel(1'b0, rand_pixel(clear_pct));
    end
    for (int i = 0; i <= eff_w(); i++)
      send_pixel($urandom_range(3) != 0, rand_pixel(clear_pct));
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // result checker and receiver ready pattern
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    pixel_out_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (filled_q.size() == 0) begin
        $display("%0t: unexpected result rgba=%h last=%b", $realtime, out_tdata, out_tlast);
        errors++;
      end else begin
        want = filled_q.pop_front();
        if (out_tdata !== want.rgba) begin
          $display("%0t: rgba mismatch expected %h actual %h", $realtime, want.rgba,
                   out_tdata);
          errors++;
        end
        if (out_tlast !== want.last) begin
          $display("%0t: frame_last mismatch expected %b actual %b", $realtime,
                   want.last, out_tlast);
          errors++;
        end
      end
    end
  end

  // hold-off is counted here, so the sender keeps pushing meanwhile
  always @(negedge clk) begin
    if (hold_ack != hold_req) begin
      hold_ack   <= hold_req;
      hold_left  <= 2000;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else begin
      out_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 25);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_count <= 0;
    else stall_count <= stall_count + 1;
    if (stall_count > 20000) begin
      $display("tb_alpha_bleed_neighbor_fill failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // 3x3 frame with some corners and edges transparent, a transparent center, channel extremes
  task automatic test_directed();
    logic [31:0] img [9];
    img = '{32'hFF_FF_FF_FF, 32'h00_12_34_56, 32'h01_00_00_00,
            32'h00_AA_BB_CC, 32'h00_00_00_00, 32'h80_01_02_03,
            32'h00_FF_FF_FF, 32'hFF_00_00_00, 32'h00_FE_FE_FE};
    write_reg(REG_WIDTH, 3);
    write_reg(REG_HEIGHT, 3);
    foreach (img[i]) send_pixel(1'b0, img[i]);
    repeat (4) send_pixel(1'b1, 32'hFFFF_FFFF);
    drain();
    // single pixel frame, isolated transparent pixel
    run_frame(1, 1, 100, 0);
    // all transparent, all opaque, flushes inside the frame
    run_frame(2, 2, 100, 0);
    run_frame(2, 2, 0, 50);
  endtask

  task automatic test_random_small();
    int sent;
    sent = 0;
    while (sent < 650) begin
      logic [15:0] w, h;
      w = $urandom_range(1, 8);
      h = $urandom_range(1, 8);
      run_frame(w, h, $urandom_range(10, 70), $urandom_range(0, 10));
      sent += w * h + w + 1;
    end
  endtask

  // no idling on either side for a while
  task automatic test_back_to_back();
    quiet = 1'b1;
    run_frame(7, 6, 40, 5);
    quiet = 1'b0;
  endtask

  // receiver stalls long enough for the block to back up its input
  task automatic test_backpressure();
    hold_req++;
    run_frame(5, 5, 40, 0);
  endtask

  // zero register values, a wide frame and a tall narrow frame
  task automatic test_extremes();
    run_frame(0, 0, 50, 0);
    run_frame(0, 4, 50, 0);
    run_frame(64, 3, 20, 0);
    run_frame(1, 200, 30, 0);
  endtask

  initial begin
    width_reg  = 2048;
    height_reg = 1;
    restart_frame();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_small();
    test_back_to_back();
    test_backpressure();
    test_extremes();
    drain();
    if (errors == 0 && filled_q.size() == 0) begin
      $display("tb_alpha_bleed_neighbor_fill passed");
    end else begin
      $display("tb_alpha_bleed_neighbor_fill failed");
    end
    $finish;
  end

endmodule
